// ----- rtl/core/u8dw_pkg.sv -----
// Package for the UTF-8 display width counter: constants, types and the width table.
`default_nettype none
package u8dw_pkg;

   localparam int SUM_BITS       = 16;
   localparam int EXT_BITS       = (SUM_BITS > 16) ? SUM_BITS : 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int ZERO_COUNT     = 139;
   localparam int WIDE_COUNT     = 14;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [20:0] SURR_LO        = 21'h00D800;
   localparam logic [20:0] SURR_HI        = 21'h00DFFF;
   localparam logic [20:0] MIN_TWO        = 21'h000080;
   localparam logic [20:0] MIN_THREE      = 21'h000800;
   localparam logic [20:0] MIN_FOUR       = 21'h010000;
   localparam logic [20:0] CTRL_END       = 21'h000020;
   localparam logic [20:0] DEL_CP         = 21'h00007F;

   typedef struct packed {
      logic [20:0] lo;
      logic [20:0] hi;
   } range_type;

   // one decoded code point on its way to the width stage
   typedef struct packed {
      logic [20:0] code_point;
      logic        was_replaced;
      logic        string_done;
      logic        run_end;
   } event_type;

   // all events caused by one byte
   typedef struct packed {
      logic      two;
      event_type ev1;
      event_type ev0;
   } group_type;

   localparam range_type ZERO_RANGES [ZERO_COUNT] = '{
      '{21'h0300,21'h036F},'{21'h0483,21'h0489},'{21'h0591,21'h05C7},'{21'h0610,21'h065F},
      '{21'h0670,21'h0670},'{21'h06D6,21'h06ED},'{21'h0711,21'h0711},'{21'h0730,21'h074A},
      '{21'h07A6,21'h07B0},'{21'h07EB,21'h07F3},'{21'h0816,21'h082D},'{21'h0859,21'h085B},
      '{21'h08D4,21'h0903},'{21'h093A,21'h093C},'{21'h093E,21'h094F},'{21'h0951,21'h0957},
      '{21'h0962,21'h0963},'{21'h0981,21'h0983},'{21'h09BC,21'h09BC},'{21'h09BE,21'h09CD},
      '{21'h09D7,21'h09D7},'{21'h09E2,21'h09E3},'{21'h0A01,21'h0A03},'{21'h0A3C,21'h0A3C},
      '{21'h0A3E,21'h0A4D},'{21'h0A51,21'h0A51},'{21'h0A70,21'h0A71},'{21'h0A75,21'h0A75},
      '{21'h0A81,21'h0A83},'{21'h0ABC,21'h0ACD},'{21'h0AE2,21'h0AE3},'{21'h0B01,21'h0B03},
      '{21'h0B3C,21'h0B3C},'{21'h0B3E,21'h0B4D},'{21'h0B56,21'h0B57},'{21'h0B62,21'h0B63},
      '{21'h0B82,21'h0B82},'{21'h0BBE,21'h0BCD},'{21'h0BD7,21'h0BD7},'{21'h0C00,21'h0C03},
      '{21'h0C3E,21'h0C4D},'{21'h0C55,21'h0C56},'{21'h0C62,21'h0C63},'{21'h0C81,21'h0C83},
      '{21'h0CBC,21'h0CCD},'{21'h0CD5,21'h0CD6},'{21'h0CE2,21'h0CE3},'{21'h0D01,21'h0D03},
      '{21'h0D3E,21'h0D4D},'{21'h0D57,21'h0D57},'{21'h0D62,21'h0D63},'{21'h0D82,21'h0D83},
      '{21'h0DCA,21'h0DDF},'{21'h0DF2,21'h0DF3},'{21'h0E31,21'h0E3A},'{21'h0E47,21'h0E4E},
      '{21'h0EB1,21'h0EB9},'{21'h0EBB,21'h0EBC},'{21'h0EC8,21'h0ECD},'{21'h0F18,21'h0F19},
      '{21'h0F35,21'h0F35},'{21'h0F37,21'h0F37},'{21'h0F39,21'h0F39},'{21'h0F3E,21'h0F3F},
      '{21'h0F71,21'h0F84},'{21'h0F86,21'h0F87},'{21'h0F8D,21'h0FBC},'{21'h0FC6,21'h0FC6},
      '{21'h102B,21'h103E},'{21'h1056,21'h1064},'{21'h1067,21'h106D},'{21'h1071,21'h1074},
      '{21'h1082,21'h108D},'{21'h108F,21'h108F},'{21'h109A,21'h109D},'{21'h135D,21'h135F},
      '{21'h1712,21'h1714},'{21'h1732,21'h1734},'{21'h1752,21'h1753},'{21'h1772,21'h1773},
      '{21'h17B4,21'h17D3},'{21'h17DD,21'h17DD},'{21'h180B,21'h180D},'{21'h1885,21'h1886},
      '{21'h18A9,21'h18A9},'{21'h1920,21'h193B},'{21'h1A17,21'h1A1B},'{21'h1A55,21'h1A7C},
      '{21'h1A7F,21'h1A7F},'{21'h1AB0,21'h1ABE},'{21'h1B00,21'h1B04},'{21'h1B34,21'h1B44},
      '{21'h1B6B,21'h1B73},'{21'h1B80,21'h1B82},'{21'h1BA1,21'h1BAD},'{21'h1BE6,21'h1BF3},
      '{21'h1C24,21'h1C37},'{21'h1CD0,21'h1CE8},'{21'h1CED,21'h1CED},'{21'h1CF2,21'h1CF9},
      '{21'h1DC0,21'h1DFF},'{21'h200B,21'h200F},'{21'h2028,21'h202E},'{21'h2060,21'h206F},
      '{21'h20D0,21'h20F0},'{21'h2CEF,21'h2CF1},'{21'h2D7F,21'h2D7F},'{21'h2DE0,21'h2DFF},
      '{21'hA66F,21'hA672},'{21'hA674,21'hA67D},'{21'hA69E,21'hA69F},'{21'hA6F0,21'hA6F1},
      '{21'hA802,21'hA802},'{21'hA806,21'hA806},'{21'hA80B,21'hA80B},'{21'hA823,21'hA827},
      '{21'hA880,21'hA881},'{21'hA8B4,21'hA8C5},'{21'hA8E0,21'hA8F1},'{21'hA926,21'hA92D},
      '{21'hA947,21'hA953},'{21'hA980,21'hA983},'{21'hA9B3,21'hA9C0},'{21'hA9E5,21'hA9E5},
      '{21'hAA29,21'hAA36},'{21'hAA43,21'hAA43},'{21'hAA4C,21'hAA4D},'{21'hAA7B,21'hAA7D},
      '{21'hAAB0,21'hAAB0},'{21'hAAB2,21'hAAB4},'{21'hAAB7,21'hAAB8},'{21'hAABE,21'hAABF},
      '{21'hAAC1,21'hAAC1},'{21'hAAEB,21'hAAEF},'{21'hAAF5,21'hAAF6},'{21'hABE3,21'hABED},
      '{21'hFE00,21'hFE0F},'{21'hFE20,21'hFE2F},'{21'hFEFF,21'hFEFF}
   };

   localparam range_type WIDE_RANGES [WIDE_COUNT] = '{
      '{21'h01100,21'h0115F},'{21'h02329,21'h0232A},'{21'h02E80,21'h0A4CF},
      '{21'h0A960,21'h0A97C},'{21'h0AC00,21'h0D7A3},'{21'h0F900,21'h0FAFF},
      '{21'h0FE10,21'h0FE19},'{21'h0FE30,21'h0FE6F},'{21'h0FF01,21'h0FF60},
      '{21'h0FFE0,21'h0FFE6},'{21'h1F300,21'h1F64F},'{21'h1F900,21'h1F9FF},
      '{21'h20000,21'h2FFFD},'{21'h30000,21'h3FFFD}
   };

   // terminal columns of a code point; the range compares run in parallel
   function automatic logic [1:0] glyph_width(input logic [20:0] cp);
      logic zero_hit;
      logic wide_hit;
      logic [1:0] w;
      zero_hit = 1'b0;
      wide_hit = 1'b0;
      for (int i = 0; i < ZERO_COUNT; i++) begin
         if (cp >= ZERO_RANGES[i].lo && cp <= ZERO_RANGES[i].hi) zero_hit = 1'b1;
      end
      for (int i = 0; i < WIDE_COUNT; i++) begin
         if (cp >= WIDE_RANGES[i].lo && cp <= WIDE_RANGES[i].hi) wide_hit = 1'b1;
      end
      if (cp < CTRL_END)      w = 2'd0;
      else if (cp < DEL_CP)   w = 2'd1;
      else if (zero_hit)      w = 2'd0;
      else if (wide_hit)      w = 2'd2;
      else                    w = 2'd1;
      return w;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/u8dw_req_if.sv -----
// Byte input channel: valid/ready handshake carrying one string byte.
`default_nettype none
interface u8dw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/u8dw_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one decoded code point.
`default_nettype none
interface u8dw_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [1:0]  glyph_width;
   logic [15:0] running_width;
   logic        was_replaced;
   logic        string_done;
   logic        run_end;

   modport source (output valid, output code_point, output glyph_width,
                   output running_width, output was_replaced, output string_done,
                   output run_end, input ready);
   modport sink   (input valid, input code_point, input glyph_width,
                   input running_width, input was_replaced, input string_done,
                   input run_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/u8dw_front.sv -----
// Front end: UTF-8 sequence decoder, turns each byte into zero, one or two events.
`default_nettype none
module u8dw_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_of_string,
   output u8dw_pkg::group_type       group,
   output logic                      push
);

   logic [1:0]  seq_len_ff, seq_len_in;
   logic [1:0]  remain_ff, remain_in;
   logic [20:0] partial_ff, partial_in;

   u8dw_pkg::event_type ev0, ev1;
   logic [1:0]  n;
   logic        consumed;
   logic [20:0] built;
   logic        bad;

   always_comb begin
      ev0        = '0;
      ev1        = '0;
      n          = 2'd0;
      consumed   = 1'b0;
      seq_len_in = seq_len_ff;
      remain_in  = remain_ff;
      partial_in = partial_ff;
      built      = {partial_ff[14:0], data_byte[5:0]};
      bad        = 1'b0;

      if (remain_ff != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            consumed   = 1'b1;
            partial_in = built;
            remain_in  = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               bad = (seq_len_ff == 2'd1 && built < u8dw_pkg::MIN_TWO)
                  || (seq_len_ff == 2'd2 && built < u8dw_pkg::MIN_THREE)
                  || (seq_len_ff == 2'd3 && built < u8dw_pkg::MIN_FOUR)
                  || (built >= u8dw_pkg::SURR_LO && built <= u8dw_pkg::SURR_HI);
               ev0.code_point   = bad ? u8dw_pkg::REPLACEMENT_CP : built;
               ev0.was_replaced = bad;
               n          = 2'd1;
               seq_len_in = 2'd0;
               partial_in = '0;
            end
         end else begin
            // broken sequence: replace it, then retry this byte as a lead
            ev0.code_point   = u8dw_pkg::REPLACEMENT_CP;
            ev0.was_replaced = 1'b1;
            n          = 2'd1;
            seq_len_in = 2'd0;
            remain_in  = 2'd0;
            partial_in = '0;
         end
      end

      if (!consumed) begin
         if (data_byte[7] == 1'b0) begin
            if (n == 2'd0) ev0.code_point = {13'd0, data_byte};
            else           ev1.code_point = {13'd0, data_byte};
            n = n + 2'd1;
         end else if (data_byte[7:5] == 3'b110) begin
            seq_len_in = 2'd1; remain_in = 2'd1; partial_in = {16'd0, data_byte[4:0]};
         end else if (data_byte[7:4] == 4'b1110) begin
            seq_len_in = 2'd2; remain_in = 2'd2; partial_in = {17'd0, data_byte[3:0]};
         end else if (data_byte[7:3] == 5'b11110) begin
            seq_len_in = 2'd3; remain_in = 2'd3; partial_in = {18'd0, data_byte[2:0]};
         end else begin
            if (n == 2'd0) begin
               ev0.code_point = u8dw_pkg::REPLACEMENT_CP; ev0.was_replaced = 1'b1;
            end else begin
               ev1.code_point = u8dw_pkg::REPLACEMENT_CP; ev1.was_replaced = 1'b1;
            end
            n = n + 2'd1;
         end
      end

      // string ends inside a sequence: one more replacement closes it
      if (end_of_string && remain_in != 2'd0) begin
         if (n == 2'd0) begin
            ev0.code_point = u8dw_pkg::REPLACEMENT_CP; ev0.was_replaced = 1'b1;
         end else begin
            ev1.code_point = u8dw_pkg::REPLACEMENT_CP; ev1.was_replaced = 1'b1;
         end
         n = n + 2'd1;
      end

      if (n == 2'd2) begin
         ev1.run_end     = 1'b1;
         ev1.string_done = end_of_string;
      end else begin
         ev0.run_end     = 1'b1;
         ev0.string_done = end_of_string;
      end

      if (end_of_string) begin
         seq_len_in = 2'd0;
         remain_in  = 2'd0;
         partial_in = '0;
      end
   end

   assign group.ev0 = ev0;
   assign group.ev1 = ev1;
   assign group.two = (n == 2'd2);
   assign push      = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= '0;
         remain_ff  <= '0;
         partial_ff <= '0;
      end else if (accept) begin
         seq_len_ff <= seq_len_in;
         remain_ff  <= remain_in;
         partial_ff <= partial_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/u8dw_queue.sv -----
// Short FIFO of event groups between the decoder and the width stage.
`default_nettype none
module u8dw_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u8dw_pkg::group_type  push_group,
   input  wire logic                 pop,
   output u8dw_pkg::group_type       head,
   output logic                      not_empty,
   output logic                      not_full
);

   u8dw_pkg::group_type slot_ff [u8dw_pkg::QUEUE_DEPTH];
   logic [u8dw_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [u8dw_pkg::QUEUE_PTR_BITS:0]   count_ff;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != (u8dw_pkg::QUEUE_PTR_BITS+1)'(u8dw_pkg::QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/u8dw_back.sv -----
// Back end: width lookup, saturating running sum and the result output register.
`default_nettype none
module u8dw_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire u8dw_pkg::group_type  head,
   input  wire logic                 not_empty,
   output logic                      pop,
   u8dw_rsp_if.source                rsp_if
);

   logic                              sel_ff;
   logic [u8dw_pkg::SUM_BITS-1:0]     total_ff;
   logic                              valid_ff;
   u8dw_pkg::event_type               out_ev_ff;
   logic [1:0]                        width_ff;
   logic [15:0]                       running_ff;

   u8dw_pkg::event_type               cur;
   logic                              load;
   logic [1:0]                        w;
   logic [u8dw_pkg::SUM_BITS:0]       sum_wide;
   logic [u8dw_pkg::SUM_BITS-1:0]     sum_sat;
   logic [u8dw_pkg::EXT_BITS-1:0]     sum_ext;

   assign cur      = sel_ff ? head.ev1 : head.ev0;
   assign load     = not_empty && (!valid_ff || rsp_if.ready);
   assign pop      = load && (sel_ff || !head.two);
   assign w        = u8dw_pkg::glyph_width(cur.code_point);
   assign sum_wide = {1'b0, total_ff} + (u8dw_pkg::SUM_BITS+1)'(w);
   assign sum_sat  = sum_wide[u8dw_pkg::SUM_BITS] ? '1 : sum_wide[u8dw_pkg::SUM_BITS-1:0];
   assign sum_ext  = u8dw_pkg::EXT_BITS'(sum_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            sel_ff   <= !pop;
            total_ff <= cur.string_done ? '0 : sum_sat;
            valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ev_ff  <= cur;
         width_ff   <= w;
         running_ff <= sum_ext[15:0];
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.code_point    = out_ev_ff.code_point;
   assign rsp_if.glyph_width   = width_ff;
   assign rsp_if.running_width = running_ff;
   assign rsp_if.was_replaced  = out_ev_ff.was_replaced;
   assign rsp_if.string_done   = out_ev_ff.string_done;
   assign rsp_if.run_end       = out_ev_ff.run_end;

   // the second event of a pair is only ever selected with a pair at the head
   a_sel_pair: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (not_empty && head.two)) else $error("second slot selected without pair");

   // sum restarts after the final code point of a string
   a_sum_restart: assert property (@(posedge clock) disable iff (reset)
      (load && cur.string_done) |=> (total_ff == '0)) else $error("sum not cleared");

   // first event of a pair never closes the byte
   a_first_open: assert property (@(posedge clock) disable iff (reset)
      (not_empty && head.two) |-> !head.ev0.run_end) else $error("pair closed early");

   // a finished string is always the end of its byte's run
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ev_ff.string_done) |-> out_ev_ff.run_end)
      else $error("string_done without run_end");

endmodule
`default_nettype wire

// ----- rtl/core/utf8_display_width_counter_top.sv -----
// Top level of the UTF-8 display width counter.
//
// req_if carries one string byte per word (data_byte, end_of_string); rsp_if
// carries one decoded code point per word with its column width, the running
// width of the string so far and the replaced, done and end-of-run flags.
// A byte gives zero, one or two result words; the byte marked end_of_string
// always gives at least one, the last with string_done set, after which the
// decoder and the width sum restart.
// A byte is taken every cycle while the four-entry group queue has room; it
// is decoded in the cycle it is taken, and its events are registered in a
// queue slot and then in the output register. The output stage gives one
// result word a cycle while the receiver is ready; pairs go out in turn.
// When the receiver stalls, the output register holds its word and the
// queue fills; req_if.ready drops only once the queue is full.
// Reset is synchronous and clears the decoder, the queue and the sum;
// no result is pending afterwards.
`default_nettype none
module utf8_display_width_counter_top (
   input  wire logic   clock,
   input  wire logic   reset,
   u8dw_req_if.sink    req_if,
   u8dw_rsp_if.source  rsp_if
);

   u8dw_pkg::group_type push_group;
   u8dw_pkg::group_type head;
   logic                push;
   logic                pop;
   logic                not_empty;
   logic                not_full;
   logic                accept;

   assign req_if.ready = not_full;
   assign accept       = req_if.valid && not_full;

   u8dw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_if.data_byte),
      .end_of_string (req_if.end_of_string),
      .group         (push_group),
      .push          (push)
   );

   u8dw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .not_full   (not_full)
   );

   u8dw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
